[hw/rtl/fwpe_pkg.sv]
package fwpe_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_W = 16;
	localparam int STATUS_W = 3;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PUSHED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POP_HEAD = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POP_URGENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic             operation;
		logic [TAG_W-1:0] entry_tag;
		logic             entry_urgent;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    popped_tag;
		logic                popped_urgent;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             urgent;
	} slot_t;

endpackage

[hw/rtl/fifo_with_priority_extraction.sv]
// Two-class priority queue of tagged entries.
// Command channel: present cmd with start; the beat is taken when start is
// high and busy is low. Operation push appends at the tail; pop removes the
// head, or with priority_enable set, the oldest urgent entry, after which
// the later entries close the gap toward the head (the head if none is urgent).
// Result channel: every command yields one result beat, shown on result for
// one cycle with done high. The receiver cannot stall; the beat must be
// taken in that cycle.
// Timing: push and refused commands give their result in the cycle after
// acceptance and leave busy low, so one command per cycle is possible.
// A head pop holds busy through S_HEAD, where the slot memory read of the
// head returns. A priority pop scans from the head one slot a cycle until the
// first urgent entry, then moves each later entry one slot per cycle through
// the separate read and write ports of the slot memory.
// Configuration: cfg_wr_en writes cfg_wr_data into priority_enable; write
// only while idle.
// Reset clears pointers, count, priority_enable and the result strobe; slot
// contents stay undefined until written and are never read before then.
module fifo_with_priority_extraction (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fwpe_pkg::cmd_t    cmd,
	output logic              done,
	output fwpe_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data
);

	localparam int QUEUE_DEPTH = fwpe_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(QUEUE_DEPTH - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

	logic [1:0]       state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             prio_en_q;
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] k_q;
	logic             done_q;
	fwpe_pkg::result_t result_q;
	fwpe_pkg::slot_t  head_save_q;
	fwpe_pkg::slot_t  taken_q;

	logic             accept;
	logic             full;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	fwpe_pkg::slot_t  ram_wdata;
	logic [PTR_W-1:0] ram_raddr;
	fwpe_pkg::slot_t  ram_rdata;
	fwpe_pkg::slot_t  head_entry;
	logic [CNT_W-1:0] count_dec;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign done = done_q;
	assign result = result_q;
	assign count_dec = count_q - 1'b1;
	assign head_entry = (k_q == '0) ? ram_rdata : head_save_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = tail_q;
		ram_wdata.tag = cmd.entry_tag;
		ram_wdata.urgent = cmd.entry_urgent;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				ram_we = accept && (cmd.operation == fwpe_pkg::OP_PUSH) && !full;
			end
			S_HEAD: begin
				ram_raddr = head_q;
			end
			S_SCAN: begin
				ram_raddr = wrap_inc(pos_q);
			end
			S_SHIFT: begin
				ram_we = (k_q < count_q);
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
				ram_raddr = wrap_inc(wrap_inc(pos_q));
			end
			default: begin
				ram_raddr = head_q;
			end
		endcase
	end

	fwpe_slot_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			prio_en_q <= 1'b0;
			pos_q <= '0;
			k_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				prio_en_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					done_q <= accept && ((cmd.operation == fwpe_pkg::OP_PUSH) ||
						(count_q == '0));
					if (accept) begin
						if (cmd.operation == fwpe_pkg::OP_PUSH) begin
							if (!full) begin
								tail_q <= wrap_inc(tail_q);
								count_q <= count_q + 1'b1;
							end
						end else if (count_q == '0) begin
							state_q <= S_IDLE;
						end else if (prio_en_q) begin
							state_q <= S_SCAN;
							pos_q <= head_q;
							k_q <= '0;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					done_q <= 1'b1;
					head_q <= wrap_inc(head_q);
					count_q <= count_dec;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					done_q <= !ram_rdata.urgent && ((k_q + 1'b1) == count_q);
					if (ram_rdata.urgent) begin
						state_q <= S_SHIFT;
						k_q <= k_q + 1'b1;
					end else if ((k_q + 1'b1) == count_q) begin
						head_q <= wrap_inc(head_q);
						count_q <= count_dec;
						k_q <= '0;
						state_q <= S_IDLE;
					end else begin
						pos_q <= wrap_inc(pos_q);
						k_q <= k_q + 1'b1;
					end
				end
				S_SHIFT: begin
					done_q <= (k_q >= count_q);
					if (k_q < count_q) begin
						pos_q <= wrap_inc(pos_q);
						k_q <= k_q + 1'b1;
					end else begin
						tail_q <= wrap_dec(tail_q);
						count_q <= count_dec;
						k_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				result_q.popped_tag <= '0;
				result_q.popped_urgent <= 1'b0;
				if (cmd.operation == fwpe_pkg::OP_PUSH) begin
					if (full) begin
						result_q.status <= fwpe_pkg::ST_FULL;
						result_q.occupancy <= fwpe_pkg::OCC_W'(count_q);
					end else begin
						result_q.status <= fwpe_pkg::ST_PUSHED;
						result_q.occupancy <= fwpe_pkg::OCC_W'(count_q + 1'b1);
					end
				end else begin
					result_q.status <= fwpe_pkg::ST_EMPTY;
					result_q.occupancy <= fwpe_pkg::OCC_W'(count_q);
				end
			end
			S_HEAD: begin
				result_q.status <= fwpe_pkg::ST_POP_HEAD;
				result_q.popped_tag <= ram_rdata.tag;
				result_q.popped_urgent <= ram_rdata.urgent;
				result_q.occupancy <= fwpe_pkg::OCC_W'(count_dec);
			end
			S_SCAN: begin
				if (k_q == '0) begin
					head_save_q <= ram_rdata;
				end
				if (ram_rdata.urgent) begin
					taken_q <= ram_rdata;
				end
				result_q.status <= fwpe_pkg::ST_POP_HEAD;
				result_q.popped_tag <= head_entry.tag;
				result_q.popped_urgent <= head_entry.urgent;
				result_q.occupancy <= fwpe_pkg::OCC_W'(count_dec);
			end
			S_SHIFT: begin
				result_q.status <= fwpe_pkg::ST_POP_URGENT;
				result_q.popped_tag <= taken_q.tag;
				result_q.popped_urgent <= taken_q.urgent;
				result_q.occupancy <= fwpe_pkg::OCC_W'(count_dec);
			end
			default: begin
				result_q.status <= fwpe_pkg::ST_EMPTY;
			end
		endcase
	end

endmodule

[hw/rtl/fwpe_slot_ram.sv]
module fwpe_slot_ram #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
	input  fwpe_pkg::slot_t                wdata,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
	output fwpe_pkg::slot_t                rdata
);

	fwpe_pkg::slot_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
